// File: hw/rtl/shader_token_stream_parser_core_defines.svh
// Assertion helpers shared by the parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SHADER_TOKEN_STREAM_PARSER_CORE_DEFINES_SVH
`define SHADER_TOKEN_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication check
`define STP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define STP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/stp_pkg.sv
`default_nettype none

package stp_pkg;

    // Result kinds
    localparam logic [3:0] KIND_HEADER    = 4'd0;
    localparam logic [3:0] KIND_BAD_TYPE  = 4'd1;
    localparam logic [3:0] KIND_LENGTH    = 4'd2;
    localparam logic [3:0] KIND_INSTR     = 4'd3;
    localparam logic [3:0] KIND_IMMEDIATE = 4'd4;
    localparam logic [3:0] KIND_HEAD_OPEN = 4'd5;
    localparam logic [3:0] KIND_HEAD_DONE = 4'd6;
    localparam logic [3:0] KIND_IDX_OPEN  = 4'd7;
    localparam logic [3:0] KIND_IDX_DONE  = 4'd8;
    localparam logic [3:0] KIND_IGNORED   = 4'd9;
    localparam logic [3:0] KIND_END       = 4'd10;

    // Version token type field (bits 31:16)
    localparam logic [15:0] TYPE_PIXEL    = 16'hFFFF;
    localparam logic [15:0] TYPE_VERTEX   = 16'hFFFE;
    localparam logic [15:0] TYPE_GEOMETRY = 16'hFFF2;
    localparam logic [15:0] TYPE_HULL     = 16'hFFF1;
    localparam logic [15:0] TYPE_DOMAIN   = 16'hFFF0;
    localparam logic [15:0] TYPE_COMPUTE  = 16'hFFF3;

    // Shader kind codes
    localparam logic [2:0] SK_PIXEL    = 3'd0;
    localparam logic [2:0] SK_VERTEX   = 3'd1;
    localparam logic [2:0] SK_GEOMETRY = 3'd2;
    localparam logic [2:0] SK_HULL     = 3'd3;
    localparam logic [2:0] SK_DOMAIN   = 3'd4;
    localparam logic [2:0] SK_COMPUTE  = 3'd5;

    // Opcode that carries one immediate word
    localparam logic [10:0] OPC_IMMEDIATE = 11'h00F;

    // Index representation meaning "no token"
    localparam logic [1:0] REP_NONE = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  shader_kind;
        logic [3:0]  major_version;
        logic [3:0]  minor_version;
        logic [10:0] opcode_value;
        logic [6:0]  instr_length;
        logic [1:0]  operand_slot;
        logic [7:0]  operand_kind;
        logic [3:0]  component_mask;
        logic [1:0]  index_dimension;
        logic [1:0]  index_slot;
        logic [31:0] word_value;
    } result_t;

    // Latched operand head
    typedef struct packed {
        logic [7:0] reps;
        logic [1:0] dim;
        logic [3:0] mask;
        logic [7:0] kind;
    } head_t;

    typedef struct packed {
        logic       known;
        logic [2:0] code;
    } type_dec_t;

    function automatic type_dec_t decode_type(input logic [15:0] t);
        type_dec_t d;
        d.known = 1'b1;
        unique case (t)
            TYPE_PIXEL:    d.code = SK_PIXEL;
            TYPE_VERTEX:   d.code = SK_VERTEX;
            TYPE_GEOMETRY: d.code = SK_GEOMETRY;
            TYPE_HULL:     d.code = SK_HULL;
            TYPE_DOMAIN:   d.code = SK_DOMAIN;
            TYPE_COMPUTE:  d.code = SK_COMPUTE;
            default:
            begin
                d.known = 1'b0;
                d.code  = 3'd0;
            end
        endcase
        return d;
    endfunction

    // First slot at or after from (below n) that takes a token, else n
    function automatic logic [2:0] next_needed(input logic [7:0] reps,
                                               input logic [2:0] n,
                                               input logic [2:0] from);
        logic [2:0] r;
        r = n;
        for (int i = 3; i >= 0; i--)
        begin
            if (3'(i) >= from && 3'(i) < n && reps[2*i +: 2] != REP_NONE)
                r = 3'(i);
        end
        return r;
    endfunction

    // Tokens used (head included) when the last slot of n is checked
    function automatic logic [2:0] used_at_last(input logic [7:0] reps,
                                                input logic [2:0] n);
        logic [2:0] cnt;
        cnt = 3'd1;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) + 3'd1 < n && reps[2*i +: 2] != REP_NONE)
                cnt = cnt + 3'd1;
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stp_parser.sv
`default_nettype none

// Parser state and per-token classification. State advances on step; the
// result for the current token is combinational from token and state.
module stp_parser #(
    parameter int MAX_OPERANDS = 4,
    parameter int MAX_INDICES  = 3
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [31:0]     token,
    input  wire logic            program_start,
    output stp_pkg::result_t     result
);
    import stp_pkg::*;

    localparam int         OPW  = $clog2(MAX_OPERANDS + 1);
    localparam logic [2:0] MAXI = 3'(MAX_INDICES);

    localparam logic [2:0] PH_HALT   = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_BODY   = 3'd2;
    localparam logic [2:0] PH_INDEX  = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]     phase_reg, phase_next;
    logic [31:0]    prog_len_reg, prog_len_next;
    logic [31:0]    position_reg, position_next;
    logic [6:0]     left_reg, left_next;
    logic [10:0]    opcode_reg, opcode_next;
    logic [6:0]     length_reg, length_next;
    logic [OPW-1:0] seen_reg, seen_next;
    logic           imm_reg, imm_next;
    head_t          head_reg, head_next;
    logic [1:0]     nidx_reg, nidx_next;

    type_dec_t   tdec;
    logic [31:0] rem;
    logic [6:0]  avail;
    logic [6:0]  left_dec;
    head_t       nh;
    logic [2:0]  nh_cnt;
    logic [2:0]  nh_first;
    logic [2:0]  nh_used;
    logic [2:0]  hd_cnt;
    logic [2:0]  hd_after;
    logic [3:0]  seen_ext;
    logic [3:0]  seen_m1;

    // Slot count of an operand head: min(dimension + 1, MAX_INDICES)
    function automatic logic [2:0] slots(input logic [1:0] dim);
        logic [2:0] d1;
        d1 = {1'b0, dim} + 3'd1;
        return (d1 < MAXI) ? d1 : MAXI;
    endfunction

    // Token decode helpers
    always_comb
    begin
        tdec     = decode_type(token[31:16]);
        rem      = prog_len_reg - position_reg;
        avail    = (rem < {25'd0, left_reg}) ? rem[6:0] : left_reg;
        left_dec = left_reg - 7'd1;
        nh.reps  = token[29:22];
        nh.dim   = token[21:20];
        nh.mask  = token[15:12];
        nh.kind  = token[7:0];
        nh_cnt   = slots(nh.dim);
        nh_first = next_needed(nh.reps, nh_cnt, 3'd0);
        nh_used  = used_at_last(nh.reps, nh_cnt);
        hd_cnt   = slots(head_reg.dim);
        hd_after = next_needed(head_reg.reps, hd_cnt, {1'b0, nidx_reg} + 3'd1);
        seen_ext = 4'(seen_reg);
        seen_m1  = seen_ext - 4'd1;
    end

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        prog_len_next = prog_len_reg;
        position_next = position_reg;
        left_next     = left_reg;
        opcode_next   = opcode_reg;
        length_next   = length_reg;
        seen_next     = seen_reg;
        imm_next      = imm_reg;
        head_next     = head_reg;
        nidx_next     = nidx_reg;
        result        = '0;
        result.kind   = KIND_IGNORED;

        priority if (program_start)
        begin
            left_next = 7'd0;
            seen_next = '0;
            imm_next  = 1'b0;
            nidx_next = 2'd0;
            if (!tdec.known)
            begin
                phase_next  = PH_HALT;
                result.kind = KIND_BAD_TYPE;
            end
            else
            begin
                phase_next           = PH_LENGTH;
                result.kind          = KIND_HEADER;
                result.shader_kind   = tdec.code;
                result.major_version = token[7:4];
                result.minor_version = token[3:0];
            end
        end
        else if (phase_reg == PH_HALT || phase_reg == PH_DONE)
        begin
            // nothing to parse until the next start
        end
        else if (phase_reg == PH_LENGTH)
        begin
            prog_len_next     = token;
            position_next     = 32'd2;
            phase_next        = PH_BODY;
            result.kind       = KIND_LENGTH;
            result.word_value = token;
        end
        else if (position_reg >= prog_len_reg)
        begin
            phase_next = PH_DONE;
        end
        else if (left_reg == 7'd0)
        begin
            // instruction head
            opcode_next         = token[10:0];
            length_next         = token[30:24];
            result.opcode_value = token[10:0];
            result.instr_length = token[30:24];
            if (token[30:24] == 7'd0)
            begin
                phase_next  = PH_DONE;
                result.kind = KIND_END;
            end
            else
            begin
                position_next = position_reg + 32'd1;
                left_next     = token[30:24] - 7'd1;
                seen_next     = '0;
                imm_next      = (token[10:0] == OPC_IMMEDIATE);
                phase_next    = PH_BODY;
                result.kind   = KIND_INSTR;
            end
        end
        else
        begin
            left_next     = left_dec;
            position_next = position_reg + 32'd1;
            priority if (phase_reg == PH_SKIP)
            begin
                if (left_dec == 7'd0)
                    phase_next = PH_BODY;
            end
            else if (opcode_reg == OPC_IMMEDIATE)
            begin
                if (imm_reg)
                begin
                    imm_next            = 1'b0;
                    result.kind         = KIND_IMMEDIATE;
                    result.opcode_value = opcode_reg;
                    result.instr_length = length_reg;
                    result.word_value   = token;
                end
            end
            else if (phase_reg == PH_INDEX)
            begin
                result.opcode_value    = opcode_reg;
                result.instr_length    = length_reg;
                result.operand_slot    = seen_m1[1:0];
                result.operand_kind    = head_reg.kind;
                result.component_mask  = head_reg.mask;
                result.index_dimension = head_reg.dim;
                result.index_slot      = nidx_reg;
                result.word_value      = token;
                if (hd_after < hd_cnt)
                begin
                    nidx_next   = hd_after[1:0];
                    result.kind = KIND_IDX_OPEN;
                end
                else
                begin
                    nidx_next   = 2'd0;
                    phase_next  = PH_BODY;
                    result.kind = KIND_IDX_DONE;
                end
            end
            else if (seen_reg >= OPW'(MAX_OPERANDS))
            begin
                // operands beyond the limit are ignored
            end
            else
            begin
                head_next = nh;
                if ({4'd0, nh_used} >= avail)
                begin
                    // operand would run past its instruction: drop the rest
                    phase_next = (left_dec == 7'd0) ? PH_BODY : PH_SKIP;
                end
                else
                begin
                    seen_next              = seen_reg + OPW'(1);
                    result.opcode_value    = opcode_reg;
                    result.instr_length    = length_reg;
                    result.operand_slot    = seen_ext[1:0];
                    result.operand_kind    = nh.kind;
                    result.component_mask  = nh.mask;
                    result.index_dimension = nh.dim;
                    if (nh_first < nh_cnt)
                    begin
                        nidx_next   = nh_first[1:0];
                        phase_next  = PH_INDEX;
                        result.kind = KIND_HEAD_OPEN;
                    end
                    else
                    begin
                        nidx_next   = 2'd0;
                        result.kind = KIND_HEAD_DONE;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HALT;
            prog_len_reg <= 32'd0;
            position_reg <= 32'd0;
            left_reg     <= 7'd0;
            opcode_reg   <= 11'd0;
            length_reg   <= 7'd0;
            seen_reg     <= '0;
            imm_reg      <= 1'b0;
            head_reg     <= '0;
            nidx_reg     <= 2'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            prog_len_reg <= prog_len_next;
            position_reg <= position_next;
            left_reg     <= left_next;
            opcode_reg   <= opcode_next;
            length_reg   <= length_next;
            seen_reg     <= seen_next;
            imm_reg      <= imm_next;
            head_reg     <= head_next;
            nidx_reg     <= nidx_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/shader_token_stream_parser_core.sv
// Shader token stream parser: takes one 32-bit bytecode token per beat and
// returns exactly one tagged result beat for it (version header, bad type,
// length, instruction head, immediate, operand head, operand index,
// ignored or end). A token is taken every cycle the result side keeps up;
// each result shows the cycle after its token, from one output register.
// The token side stalls only while the consumer stalls the held result.
// A token with program_start set restarts parsing at any point.
`default_nettype none

`include "shader_token_stream_parser_core_defines.svh"

module shader_token_stream_parser_core #(
    parameter int MAX_OPERANDS = 4,
    parameter int MAX_INDICES  = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // token channel
    input  wire logic        token_valid,
    output logic             token_stall,
    input  wire logic [31:0] token,
    input  wire logic        program_start,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [3:0]       kind,
    output logic [2:0]       shader_kind,
    output logic [3:0]       major_version,
    output logic [3:0]       minor_version,
    output logic [10:0]      opcode_value,
    output logic [6:0]       instr_length,
    output logic [1:0]       operand_slot,
    output logic [7:0]       operand_kind,
    output logic [3:0]       component_mask,
    output logic [1:0]       index_dimension,
    output logic [1:0]       index_slot,
    output logic [31:0]      word_value
);
    import stp_pkg::*;

    logic    accept;
    logic    valid_reg;
    result_t step_result;
    result_t result_reg;

    // Token side waits only on a stalled, full result register
    assign token_stall = valid_reg && result_stall;
    assign accept      = token_valid && !token_stall;

    stp_parser #(
        .MAX_OPERANDS (MAX_OPERANDS),
        .MAX_INDICES  (MAX_INDICES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .token         (token),
        .program_start (program_start),
        .result        (step_result)
    );

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= step_result;
    end

    assign result_valid    = valid_reg;
    assign kind            = result_reg.kind;
    assign shader_kind     = result_reg.shader_kind;
    assign major_version   = result_reg.major_version;
    assign minor_version   = result_reg.minor_version;
    assign opcode_value    = result_reg.opcode_value;
    assign instr_length    = result_reg.instr_length;
    assign operand_slot    = result_reg.operand_slot;
    assign operand_kind    = result_reg.operand_kind;
    assign component_mask  = result_reg.component_mask;
    assign index_dimension = result_reg.index_dimension;
    assign index_slot      = result_reg.index_slot;
    assign word_value      = result_reg.word_value;

    // Checks
    `STP_ASSERT_NEXT(a_beat_gives_result, accept, valid_reg,
        "accepted token produced no result")
    `STP_ASSERT_SAME(a_header_fields_only, valid_reg && result_reg.kind != KIND_HEADER,
        result_reg.shader_kind == 3'd0 && result_reg.major_version == 4'd0 &&
        result_reg.minor_version == 4'd0, "version fields set outside header result")
    `STP_ASSERT_SAME(a_index_slot_only,
        valid_reg && result_reg.kind != KIND_IDX_OPEN && result_reg.kind != KIND_IDX_DONE,
        result_reg.index_slot == 2'd0, "index slot set outside index result")

endmodule

`default_nettype wire
